// File: sv/vtc_pkg.sv
// Package for the virtual translation cache: entry geometry, field widths,
// request and key codes, and the packed entry type kept in the entry memory.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vtc_pkg;

    // Entries in each of the two translation caches.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int BASE_W  = 61;
    localparam int ASN_W   = 10;
    localparam int IDENT_W = 12;
    localparam int PSB_W   = 6;
    localparam int PROT_W  = 3;
    localparam int WORD_W  = 64;

    localparam logic [PSB_W-1:0] PSB_RESET = 6'd13;

    // Request kinds.
    localparam logic [1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [1:0] KIND_STORE     = 2'd1;
    localparam logic [1:0] KIND_UPDATE    = 2'd2;

    // Key codes of an update request.
    localparam logic [2:0] CODE_DELETE  = 3'd0;
    localparam logic [2:0] CODE_PROBE_D = 3'd1;
    localparam logic [2:0] CODE_PROBE_I = 3'd2;
    localparam logic [2:0] CODE_XLATE_D = 3'd6;
    localparam logic [2:0] CODE_XLATE_I = 3'd7;

    // Register addresses are selected by this paddr bit.
    localparam logic REG_PAGE_SIZE = 1'b0;
    localparam logic REG_ASN       = 1'b1;

    localparam logic [BASE_W-1:0] KEY_LOW_MASK = 61'h1FF;
    localparam logic [WORD_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [PROT_W-1:0]  prot;
        logic [IDENT_W-1:0] ident;
        logic [BASE_W-1:0]  vbase;
        logic [BASE_W-1:0]  pbase;
    } t_entry;

endpackage

`default_nettype wire

// File: sv/virtual_translation_cache.sv
// Virtual translation cache top level: two fully associative caches searched
// one entry per cycle by a small sequencer, plus the APB register port.
// Depends on vtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   | Direction | Handshake           | Payload
//  ----------+-----------+---------------------+-------------------------------------
//  request   | in        | i_valid / o_ready   | i_kind, i_which_cache, i_addr_word,
//            |           |                     | i_phys_word
//  response  | out       | o_valid / i_ready   | o_hit, o_protection, o_result_word
//  config    | in        | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// A translate or probe is accepted in the idle state, searched with one entry compare per cycle
// from the single memory read port, and then answered from the finish state.
// A delete searches the data cache, then the instruction cache; store and unused requests skip the search.
// Reset is synchronous and active low; it clears every valid flag at once, so no clearing pass.
// Requests are taken only while the sequencer is idle. A response may wait in the output
// register while the next transaction is searched; that one then holds in its finish state.

module virtual_translation_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic                        i_which_cache,
    input  logic [vtc_pkg::WORD_W-1:0]  i_addr_word,
    input  logic [vtc_pkg::WORD_W-1:0]  i_phys_word,
    // response
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [vtc_pkg::PROT_W-1:0]  o_protection,
    output logic [vtc_pkg::WORD_W-1:0]  o_result_word,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FIN} t_state;
    typedef enum logic [1:0] {OP_NONE, OP_TRANSLATE, OP_PROBE, OP_DELETE} t_op;

    localparam logic [vtc_pkg::IDX_W-1:0] LAST_IDX = vtc_pkg::IDX_W'(vtc_pkg::ENTRIES - 1);
    localparam logic [vtc_pkg::CNT_W-1:0] FULL_CNT = vtc_pkg::CNT_W'(vtc_pkg::ENTRIES);

    t_state                        r_state;
    t_op                           r_op;
    logic [vtc_pkg::PSB_W-1:0]     r_psb;
    logic [vtc_pkg::ASN_W-1:0]     r_asn;
    logic [vtc_pkg::IDX_W-1:0]     r_fp [0:1];

    // One valid flag per entry; an entry with zero protection is never valid.
    logic [vtc_pkg::ENTRIES-1:0]   r_live [0:1];
    // Protection, identifier and page bases only matter while the entry is valid.
    vtc_pkg::t_entry               r_mem  [0:1][0:vtc_pkg::ENTRIES-1];

    // Search sequencer.
    logic                          r_cache;
    logic [vtc_pkg::IDX_W-1:0]     r_idx;
    logic [vtc_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_rd_vld;
    logic [vtc_pkg::IDX_W-1:0]     r_rd_idx;
    logic                          r_rd_live;
    vtc_pkg::t_entry               r_rd_entry;

    // Query captured at acceptance.
    logic [vtc_pkg::IDENT_W-1:0]   r_q_ident;
    logic [vtc_pkg::BASE_W-1:0]    r_q_base;
    logic [vtc_pkg::WORD_W-1:0]    r_q_off;

    // Search outcome.
    logic                          r_found;
    logic [vtc_pkg::PROT_W-1:0]    r_f_prot;
    logic [vtc_pkg::BASE_W-1:0]    r_f_pbase;

    // Output register.
    logic                          r_out_vld;
    logic                          r_hit;
    logic [vtc_pkg::PROT_W-1:0]    r_oprot;
    logic [vtc_pkg::WORD_W-1:0]    r_word;

    logic                          in_fire;
    logic                          cfg_wr;
    logic [vtc_pkg::WORD_W-1:0]    off_mask;
    logic [1:0]                    in_seg;
    logic [2:0]                    in_code;
    logic [vtc_pkg::BASE_W-1:0]    xl_base;
    logic [vtc_pkg::BASE_W-1:0]    key_base;
    logic [vtc_pkg::PROT_W-1:0]    st_prot;
    logic [vtc_pkg::IDX_W-1:0]     n_fp;
    logic [vtc_pkg::IDX_W-1:0]     n_idx;
    logic                          is_store;
    logic                          match;
    logic                          pass_end;
    logic                          out_free;
    t_op                           n_op;
    logic                          n_cache;
    logic [vtc_pkg::WORD_W-1:0]    n_word;
    logic [vtc_pkg::PROT_W-1:0]    n_oprot;

    assign o_ready       = (r_state == S_IDLE);
    assign in_fire       = i_valid && o_ready;
    assign o_valid       = r_out_vld;
    assign o_hit         = r_hit;
    assign o_protection  = r_oprot;
    assign o_result_word = r_word;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign out_free      = !r_out_vld || i_ready;

    assign prdata = (paddr[2] == vtc_pkg::REG_ASN) ? {22'd0, r_asn} : {26'd0, r_psb};

    // The page size splits an address into its page base and its offset.
    assign off_mask = ~(vtc_pkg::ALL_ONES << r_psb);
    assign in_seg   = i_addr_word[62:61];
    assign in_code  = i_addr_word[2:0];
    assign xl_base  = i_addr_word[vtc_pkg::BASE_W-1:0] & ~off_mask[vtc_pkg::BASE_W-1:0];
    assign key_base = i_addr_word[vtc_pkg::BASE_W-1:0] & ~vtc_pkg::KEY_LOW_MASK;
    assign st_prot  = i_phys_word[vtc_pkg::PROT_W-1:0] & off_mask[vtc_pkg::PROT_W-1:0];
    assign is_store = in_fire && (i_kind == vtc_pkg::KIND_STORE);

    // Round-robin pointers wrap at the last entry.
    assign n_fp  = (r_fp[i_which_cache] == LAST_IDX) ? '0
                                                     : r_fp[i_which_cache] + 1'b1;
    assign n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    // One entry is compared per cycle against the captured query.
    assign match = r_rd_vld && r_rd_live &&
                   (r_rd_entry.ident == r_q_ident) && (r_rd_entry.vbase == r_q_base);
    // A pass ends on the first match or once every entry has been compared.
    assign pass_end = match || (!r_rd_vld && (r_cnt == FULL_CNT));

    // Decode of the request into the operation the sequencer runs.
    always_comb begin
        n_op    = OP_NONE;
        n_cache = i_which_cache;
        case (i_kind)
            vtc_pkg::KIND_TRANSLATE: begin
                n_op = OP_TRANSLATE;
            end
            vtc_pkg::KIND_UPDATE: begin
                case (in_code)
                    vtc_pkg::CODE_DELETE: begin
                        n_op    = OP_DELETE;
                        n_cache = 1'b0;
                    end
                    vtc_pkg::CODE_PROBE_D, vtc_pkg::CODE_XLATE_D: begin
                        n_op    = OP_PROBE;
                        n_cache = 1'b0;
                    end
                    vtc_pkg::CODE_PROBE_I, vtc_pkg::CODE_XLATE_I: begin
                        n_op    = OP_PROBE;
                        n_cache = 1'b1;
                    end
                    default: begin
                        n_op = OP_NONE;
                    end
                endcase
            end
            default: begin
                n_op = OP_NONE;
            end
        endcase
    end

    // The response is formed from the captured outcome in the finish state.
    always_comb begin
        n_word  = vtc_pkg::ALL_ONES;
        n_oprot = '0;
        if (r_found) begin
            case (r_op)
                OP_TRANSLATE: begin
                    n_word  = {3'd0, r_f_pbase} + r_q_off;
                    n_oprot = r_f_prot;
                end
                OP_PROBE: begin
                    n_word  = {3'd0, r_f_pbase | {58'd0, r_f_prot}};
                    n_oprot = r_f_prot;
                end
                default: begin
                    n_word  = vtc_pkg::ALL_ONES;
                    n_oprot = '0;
                end
            endcase
        end
    end

    // Entry memory: written by a store at acceptance, read once per cycle.
    always_ff @(posedge i_clk) begin
        if (is_store) begin
            r_mem[i_which_cache][n_fp] <= '{
                prot:  st_prot,
                ident: {in_seg, r_asn},
                vbase: xl_base,
                pbase: i_phys_word[vtc_pkg::BASE_W-1:0] & ~off_mask[vtc_pkg::BASE_W-1:0]
            };
        end
        r_rd_entry <= r_mem[r_cache][r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_NONE;
            r_psb     <= vtc_pkg::PSB_RESET;
            r_asn     <= '0;
            r_fp[0]   <= '0;
            r_fp[1]   <= '0;
            r_live[0] <= '0;
            r_live[1] <= '0;
            r_cache   <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == vtc_pkg::REG_ASN) begin
                    r_asn <= pwdata[vtc_pkg::ASN_W-1:0];
                end else begin
                    r_psb <= pwdata[vtc_pkg::PSB_W-1:0];
                end
            end

            // Valid flag of the entry addressed this cycle, aligned with memory.
            r_rd_live <= r_live[r_cache][r_idx];
            r_rd_idx  <= r_idx;

            if (out_free && (r_state != S_FIN)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op      <= n_op;
                        r_cache   <= n_cache;
                        r_idx     <= r_fp[n_cache];
                        r_cnt     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_found   <= 1'b0;
                        r_q_off   <= i_addr_word & off_mask;
                        if (i_kind == vtc_pkg::KIND_TRANSLATE) begin
                            r_q_ident <= {in_seg, r_asn};
                            r_q_base  <= xl_base;
                        end else begin
                            r_q_ident <= {in_seg, i_addr_word[12:3]};
                            r_q_base  <= key_base;
                        end
                        if (is_store) begin
                            r_fp[i_which_cache]         <= n_fp;
                            r_live[i_which_cache][n_fp] <= (st_prot != '0);
                        end
                        r_state <= (n_op == OP_NONE) ? S_FIN : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (pass_end) begin
                        r_rd_vld <= 1'b0;
                        if (match) begin
                            r_found   <= 1'b1;
                            r_f_prot  <= r_rd_entry.prot;
                            r_f_pbase <= r_rd_entry.pbase;
                            if (r_op == OP_DELETE) begin
                                r_live[r_cache][r_rd_idx] <= 1'b0;
                            end
                        end
                        // A delete goes on to the instruction cache.
                        if ((r_op == OP_DELETE) && !r_cache) begin
                            r_cache <= 1'b1;
                            r_idx   <= r_fp[1];
                            r_cnt   <= '0;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (r_cnt != FULL_CNT) begin
                        r_idx    <= n_idx;
                        r_cnt    <= r_cnt + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_hit     <= r_found;
                        r_oprot   <= n_oprot;
                        r_word    <= n_word;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The search counter never runs past the number of entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("search counter exceeded the entry count");

    // The scan index always addresses an existing entry.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("scan index out of range");

    // An accepted transaction always leaves the idle state.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a transaction");

    // A store into the data cache moves its fill pointer.
    a_fill_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_store && !i_which_cache) |=> (r_fp[0] != $past(r_fp[0])))
        else $error("data fill pointer did not advance on a store");
`endif

endmodule

`default_nettype wire
